// ----- rtl/ssbr_pkg.sv -----
// Shared types, constants and helper functions for the seven-segment refresh block.
package ssbr_pkg;

	localparam logic [7:0] MINUS_CODE = 8'h40;
	localparam logic [7:0] POINT_BIT  = 8'h80;
	localparam logic [6:0] CMD_BASE   = 7'h68;
	localparam logic [1:0] FRAME_LAST = 2'd3;
	localparam logic [2:0] PHASE_WRAP = 3'd6;
	localparam logic [31:0] RECIP_10  = 32'd52429;
	localparam int          RECIP_SH  = 19;
	localparam int          FIFO_DEPTH = 2;

	typedef struct packed {
		logic              blank;
		logic              number_mode;
		logic              neg;
		logic [3:0]        dot_mask;
		logic [3:0][7:0]   text;
		logic [3:0][3:0]   digits;
	} ssbr_ctrl_t;

	typedef struct packed {
		logic [3:0][7:0] seg;
	} ssbr_word_t;

	typedef struct packed {
		logic [15:0] quot;
		logic [3:0]  rem;
	} ssbr_div_t;

	function automatic ssbr_div_t div10(input logic [15:0] v);
		ssbr_div_t   res;
		logic [31:0] prod;
		logic [15:0] tenq;
		prod     = {16'd0, v} * RECIP_10;
		res.quot = 16'(prod >> RECIP_SH);
		tenq     = 16'({res.quot, 3'b000} + {2'b00, res.quot, 1'b0});
		res.rem  = 4'(v - tenq);
		return res;
	endfunction

	function automatic logic [7:0] seg_of(input logic [3:0] d);
		logic [7:0] code;
		case (d)
			4'd0: code = 8'h3F;
			4'd1: code = 8'h06;
			4'd2: code = 8'h5B;
			4'd3: code = 8'h4F;
			4'd4: code = 8'h66;
			4'd5: code = 8'h6D;
			4'd6: code = 8'h7D;
			4'd7: code = 8'h07;
			4'd8: code = 8'h7F;
			4'd9: code = 8'h6F;
			default: code = 8'h00;
		endcase
		return code;
	endfunction

endpackage

// ----- rtl/ssbr_front.sv -----
// Front end: accepts ticks, steps the blink and dot state, extracts decimal digits.
module ssbr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [15:0]         shown_number,
	input  logic                number_mode,
	input  logic [7:0]          text_seg0,
	input  logic [7:0]          text_seg1,
	input  logic [7:0]          text_seg2,
	input  logic [7:0]          text_seg3,
	input  logic                blink_enable,
	input  logic                fixed_dot_enable,
	input  logic                running_dot_enable,
	output logic                push,
	input  logic                push_ready,
	output ssbr_pkg::ssbr_word_t push_word
);
	import ssbr_pkg::*;

	logic [2:0]  tick_phase_q;
	logic        blink_phase_q;
	logic [1:0]  dot_pos_q;
	logic [2:0]  tick_next;
	logic        blink_next;
	logic [1:0]  dot_next;
	logic [3:0]  mask_next;
	logic [15:0] mag;
	logic [3:0]  inc_sum;
	logic        adv;
	logic        accept;
	ssbr_ctrl_t  ctrl_in;

	logic        val_s1, val_s2, val_s3, val_s4, val_s5;
	ssbr_ctrl_t  ctrl_s1, ctrl_s2, ctrl_s3, ctrl_s4, ctrl_s5;
	ssbr_ctrl_t  ctrl_d2, ctrl_d3, ctrl_d4, ctrl_d5;
	logic [15:0] num_s1, num_s2, num_s3, num_s4;
	ssbr_div_t   div_1, div_2, div_3, div_4;

	assign adv      = !val_s5 || push_ready;
	assign in_ready = adv;
	assign accept   = in_valid && adv;
	assign push     = val_s5 && push_ready;

	always_comb begin
		inc_sum   = {1'b0, tick_phase_q} + 4'd1;
		tick_next = (inc_sum >= {1'b0, PHASE_WRAP}) ? 3'(inc_sum - {1'b0, PHASE_WRAP})
			: inc_sum[2:0];
		blink_next = blink_phase_q ^ (tick_next inside {3'd0, 3'd3});
		dot_next   = dot_pos_q;
		mask_next  = 4'b0000;
		if (fixed_dot_enable) begin
			mask_next = 4'b0001;
		end else if (running_dot_enable) begin
			if (!tick_next[0]) begin
				dot_next = dot_pos_q + 2'd1;
			end
			mask_next = 4'b0001 << dot_next;
		end
		mag = shown_number[15] ? 16'(~shown_number + 16'd1) : shown_number;
		ctrl_in.blank       = blink_enable && !blink_phase_q;
		ctrl_in.number_mode = number_mode;
		ctrl_in.neg         = shown_number[15];
		ctrl_in.dot_mask    = mask_next;
		ctrl_in.text        = {text_seg3, text_seg2, text_seg1, text_seg0};
		ctrl_in.digits      = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_phase_q  <= '0;
			blink_phase_q <= 1'b0;
			dot_pos_q     <= '0;
		end else if (accept) begin
			tick_phase_q  <= tick_next;
			blink_phase_q <= blink_next;
			dot_pos_q     <= dot_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1 <= 1'b0;
			val_s2 <= 1'b0;
			val_s3 <= 1'b0;
			val_s4 <= 1'b0;
			val_s5 <= 1'b0;
		end else if (adv) begin
			val_s1 <= in_valid;
			val_s2 <= val_s1;
			val_s3 <= val_s2;
			val_s4 <= val_s3;
			val_s5 <= val_s4;
		end
	end

	assign div_1 = div10(num_s1);
	assign div_2 = div10(num_s2);
	assign div_3 = div10(num_s3);
	assign div_4 = div10(num_s4);

	always_comb begin
		ctrl_d2           = ctrl_s1;
		ctrl_d2.digits[0] = div_1.rem;
		ctrl_d3           = ctrl_s2;
		ctrl_d3.digits[1] = div_2.rem;
		ctrl_d4           = ctrl_s3;
		ctrl_d4.digits[2] = div_3.rem;
		ctrl_d5           = ctrl_s4;
		ctrl_d5.digits[3] = div_4.rem;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctrl_s1 <= ctrl_in;
			num_s1  <= mag;
			ctrl_s2 <= ctrl_d2;
			num_s2  <= div_1.quot;
			ctrl_s3 <= ctrl_d3;
			num_s3  <= div_2.quot;
			ctrl_s4 <= ctrl_d4;
			num_s4  <= div_3.quot;
			ctrl_s5 <= ctrl_d5;
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			if (ctrl_s5.blank) begin
				push_word.seg[k] = 8'h00;
			end else if (ctrl_s5.number_mode) begin
				push_word.seg[k] = (k == 3 && ctrl_s5.neg) ? MINUS_CODE
					: seg_of(ctrl_s5.digits[k]);
			end else begin
				push_word.seg[k] = ctrl_s5.text[k];
			end
			if (ctrl_s5.dot_mask[k]) begin
				push_word.seg[k] = push_word.seg[k] | POINT_BIT;
			end
		end
	end

endmodule

// ----- rtl/ssbr_fifo.sv -----
// Two-entry queue of digit words between the front end and the frame sender.
module ssbr_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 push_ready,
	input  ssbr_pkg::ssbr_word_t push_word,
	output logic                 pop_valid,
	input  logic                 pop,
	output ssbr_pkg::ssbr_word_t pop_word
);
	import ssbr_pkg::*;

	ssbr_word_t mem_q [FIFO_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'(FIFO_DEPTH));
	assign pop_valid  = (count_q != 2'd0);
	assign pop_word   = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/ssbr_back.sv -----
// Back end: sends four command and segment frames for each queued digit word.
module ssbr_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pop_valid,
	output logic                 pop,
	input  ssbr_pkg::ssbr_word_t pop_word,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [6:0]           command_byte,
	output logic [7:0]           segment_byte,
	output logic                 last_frame
);
	import ssbr_pkg::*;

	logic       busy_q;
	logic [1:0] cnt_q;
	ssbr_word_t word_q;
	logic       fire;
	logic       done;
	logic       load;
	logic [1:0] digit_sel;

	assign out_valid    = busy_q;
	assign fire         = busy_q && out_ready;
	assign done         = fire && (cnt_q == FRAME_LAST);
	assign load         = !busy_q || done;
	assign pop          = load && pop_valid;
	assign digit_sel    = cnt_q + 2'd1;
	assign command_byte = CMD_BASE + {4'd0, cnt_q, 1'b0};
	assign segment_byte = word_q.seg[digit_sel];
	assign last_frame   = (cnt_q == FRAME_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load) begin
			busy_q <= pop_valid;
			cnt_q  <= '0;
		end else if (fire) begin
			cnt_q <= cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			word_q <= pop_word;
		end
	end

`ifndef SYNTHESIS
	a_frame_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire && cnt_q != FRAME_LAST |=> busy_q && cnt_q == $past(cnt_q) + 2'd1)
		else $error("frame counter did not advance");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !out_ready |=> busy_q && $stable(cnt_q) && $stable(word_q))
		else $error("frame changed while stalled");
	a_start_first: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> cnt_q == 2'd0)
		else $error("word started at a later frame");
`endif

endmodule

// ----- rtl/seven_segment_blink_refresh.sv -----
// Top level: four-digit seven-segment refresh with blink and running dot.
// A tick passes the front-end pipeline registers and the two-entry queue before the sender loads it.
// Throughput: one frame per cycle from the frame sender while out_ready is high.
// The front end takes a tick every cycle until the two-entry queue is full and its last stage holds a word.
// Reset clears tick and blink phase, dot position, pipeline, queue and sender.
module seven_segment_blink_refresh (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] shown_number,
	input  logic        number_mode,
	input  logic [7:0]  text_seg0,
	input  logic [7:0]  text_seg1,
	input  logic [7:0]  text_seg2,
	input  logic [7:0]  text_seg3,
	input  logic        blink_enable,
	input  logic        fixed_dot_enable,
	input  logic        running_dot_enable,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [6:0]  command_byte,
	output logic [7:0]  segment_byte,
	output logic        last_frame
);
	import ssbr_pkg::*;

	logic       push;
	logic       push_ready;
	ssbr_word_t push_word;
	logic       pop_valid;
	logic       pop;
	ssbr_word_t pop_word;

	ssbr_front u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.shown_number       (shown_number),
		.number_mode        (number_mode),
		.text_seg0          (text_seg0),
		.text_seg1          (text_seg1),
		.text_seg2          (text_seg2),
		.text_seg3          (text_seg3),
		.blink_enable       (blink_enable),
		.fixed_dot_enable   (fixed_dot_enable),
		.running_dot_enable (running_dot_enable),
		.push               (push),
		.push_ready         (push_ready),
		.push_word          (push_word)
	);

	ssbr_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_word  (push_word),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_word   (pop_word)
	);

	ssbr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop          (pop),
		.pop_word     (pop_word),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.command_byte (command_byte),
		.segment_byte (segment_byte),
		.last_frame   (last_frame)
	);

endmodule

// ----- bench/tb_top.sv -----
// Testbench for the seven-segment refresh block: predicts the four frames of every tick and checks them.
module tb_top;
	import ssbr_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 16;
	localparam int RANDOM_TICKS = 200;
	localparam int LONG_HOLD    = 80;
	localparam logic [9:0][7:0] DIGIT_SEG = {
		8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
	};

	typedef struct packed {
		logic [15:0]     number;
		logic            number_mode;
		logic [3:0][7:0] text;
		logic            blink;
		logic            fixed_dot;
		logic            running_dot;
	} tick_t;

	typedef struct packed {
		logic [6:0] cmd;
		logic [7:0] seg;
		logic       last;
	} frame_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [15:0] shown_number = '0;
	logic        number_mode = 1'b0;
	logic [7:0]  text_seg0 = '0;
	logic [7:0]  text_seg1 = '0;
	logic [7:0]  text_seg2 = '0;
	logic [7:0]  text_seg3 = '0;
	logic        blink_enable = 1'b0;
	logic        fixed_dot_enable = 1'b0;
	logic        running_dot_enable = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [6:0]  command_byte;
	logic [7:0]  segment_byte;
	logic        last_frame;

	logic [2:0]  tick_phase = '0;
	logic        blink_phase = 1'b0;
	logic [1:0]  dot_position = '0;
	frame_t      expected_frames[$];

	int          mismatch_count = 0;
	int          ticks_sent = 0;
	int          frames_checked = 0;
	int          cycle_count = 0;

	logic        hold_req = 1'b0;
	logic        hold_seen = 1'b0;
	int          hold_left = 0;
	int          rx_cycle = 0;
	int unsigned rx_mode = 0;

	seven_segment_blink_refresh DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.shown_number(shown_number),
		.number_mode(number_mode),
		.text_seg0(text_seg0),
		.text_seg1(text_seg1),
		.text_seg2(text_seg2),
		.text_seg3(text_seg3),
		.blink_enable(blink_enable),
		.fixed_dot_enable(fixed_dot_enable),
		.running_dot_enable(running_dot_enable),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.command_byte(command_byte),
		.segment_byte(segment_byte),
		.last_frame(last_frame)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d frames still expected",
				cycle_count, expected_frames.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at cycle %0d, frame %0d: %s got 0x%0h expected 0x%0h",
			cycle_count, frames_checked, what, got, want);
		mismatch_count++;
	endtask

	task automatic predict_frames(input tick_t t);
		logic [3:0][7:0] seg;
		int unsigned     value;
		frame_t          f;
		if (t.blink && !blink_phase) begin
			seg = '0;
		end else if (t.number_mode) begin
			if (t.number[15])
				value = 32'h10000 - 32'(t.number);
			else
				value = 32'(t.number);
			seg[0] = DIGIT_SEG[value % 10];
			seg[1] = DIGIT_SEG[(value / 10) % 10];
			seg[2] = DIGIT_SEG[(value / 100) % 10];
			seg[3] = t.number[15] ? MINUS_CODE : DIGIT_SEG[(value / 1000) % 10];
		end else begin
			seg = t.text;
		end
		tick_phase = 3'((int'(tick_phase) + 1) % int'(PHASE_WRAP));
		if (tick_phase % 3 == 0)
			blink_phase = ~blink_phase;
		if (t.fixed_dot) begin
			seg[0] = seg[0] | POINT_BIT;
		end else if (t.running_dot) begin
			if (!tick_phase[0])
				dot_position = dot_position + 2'd1;
			seg[dot_position] = seg[dot_position] | POINT_BIT;
		end
		for (int k = 0; k < 4; k++) begin
			f.cmd  = CMD_BASE + 7'(2 * k);
			f.seg  = seg[(k + 1) % 4];
			f.last = (k == 3);
			expected_frames.push_back(f);
		end
	endtask

	task automatic send_tick(input tick_t t);
		in_valid           <= 1'b1;
		shown_number       <= t.number;
		number_mode        <= t.number_mode;
		text_seg0          <= t.text[0];
		text_seg1          <= t.text[1];
		text_seg2          <= t.text[2];
		text_seg3          <= t.text[3];
		blink_enable       <= t.blink;
		fixed_dot_enable   <= t.fixed_dot;
		running_dot_enable <= t.running_dot;
		do
			@(posedge clk);
		while (!in_ready);
		predict_frames(t);
		ticks_sent++;
	endtask

	task automatic idle_gap(input int cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_frames.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic tick_t number_tick(input logic [15:0] n, input logic blink,
		input logic fixed_dot, input logic running_dot);
		tick_t t;
		t.number      = n;
		t.number_mode = 1'b1;
		t.text        = 32'h0;
		t.blink       = blink;
		t.fixed_dot   = fixed_dot;
		t.running_dot = running_dot;
		return t;
	endfunction

	function automatic tick_t random_tick();
		tick_t t;
		case ($urandom_range(0, 3))
			0: t.number = 16'($urandom);
			1: t.number = 16'($urandom_range(0, 9999));
			2: t.number = 16'(-int'($urandom_range(1, 999)));
			default: t.number = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
		endcase
		t.number_mode = ($urandom_range(0, 9) < 7);
		t.text        = $urandom;
		t.blink       = 1'($urandom_range(0, 1));
		t.fixed_dot   = ($urandom_range(0, 9) < 3);
		t.running_dot = ($urandom_range(0, 9) < 6);
		return t;
	endfunction

	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle % 32 == 0)
			rx_mode <= $urandom_range(0, 3);
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= LONG_HOLD;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 4) != 0);
				default: out_ready <= (rx_cycle % 4 != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		frame_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_frames.size() == 0) begin
				report_mismatch("frame with nothing expected, command",
					int'(command_byte), 0);
			end else begin
				want = expected_frames.pop_front();
				if (command_byte !== want.cmd)
					report_mismatch("command_byte", int'(command_byte), int'(want.cmd));
				if (segment_byte !== want.seg)
					report_mismatch("segment_byte", int'(segment_byte), int'(want.seg));
				if (last_frame !== want.last)
					report_mismatch("last_frame", int'(last_frame), int'(want.last));
			end
			frames_checked++;
		end
	end

	task automatic test_number_extremes();
		logic [15:0] values [13];
		values = '{16'd0, 16'd1, 16'd9, 16'd10, 16'd9999, 16'd10000, 16'd32767,
			16'hFFFF, 16'(-9), 16'(-999), 16'(-1000), 16'h8000, 16'd12345};
		foreach (values[i])
			send_tick(number_tick(values[i], 1'b0, 1'b0, 1'b0));
		idle_gap(3);
	endtask

	task automatic test_text_patterns();
		tick_t t;
		logic [31:0] patterns [4];
		patterns = '{32'h00000000, 32'hFFFFFFFF, 32'h08040201, 32'h10204080};
		foreach (patterns[i]) begin
			t = number_tick(16'd0, 1'b0, 1'b0, 1'b0);
			t.number_mode = 1'b0;
			t.text = patterns[i];
			send_tick(t);
			idle_gap(i);
		end
	endtask

	task automatic test_blink_and_dots();
		for (int i = 0; i < 8; i++)
			send_tick(number_tick(16'(1234 + i), 1'b1, i % 3 == 2, 1'b1));
		wait_drained();
	endtask

	task automatic test_backpressure();
		hold_req <= ~hold_req;
		for (int i = 0; i < 10; i++)
			send_tick(random_tick());
		wait_drained();
	endtask

	task automatic test_random_ticks();
		int burst_left;
		burst_left = $urandom_range(1, 12);
		for (int i = 0; i < RANDOM_TICKS; i++) begin
			send_tick(random_tick());
			burst_left--;
			if (burst_left == 0) begin
				idle_gap($urandom_range(0, 10));
				burst_left = $urandom_range(1, 12);
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_number_extremes();
		test_text_patterns();
		test_blink_and_dots();
		test_backpressure();
		test_random_ticks();
		wait_drained();
		$display("Ran %0d ticks: number extremes, text bytes, blink with both dots,",
			ticks_sent);
		$display("a long output hold-off and bursty random ticks; %0d frames checked.",
			frames_checked);
		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
